// File: design/ttu_pkg.sv
// shared types and constants for the uv tangent block
`default_nettype none
package ttu_pkg;

  localparam int CW        = 32;          // coordinate width
  localparam int FB        = 16;          // fraction bits
  localparam int TRI_VERTS = 3;           // vertices per triangle
  localparam int DELTA_W   = CW + 1;      // difference of two coordinates
  localparam int PROD_W    = 2 * DELTA_W; // product of two deltas
  localparam int WIDE_W    = PROD_W + 1;  // difference of two products

  typedef struct packed {
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] pos_z;
    logic signed [CW-1:0] tex_u;
    logic signed [CW-1:0] tex_v;
  } vertex_t;

  typedef struct packed {
    logic signed [CW-1:0] tangent_x;
    logic signed [CW-1:0] tangent_y;
    logic signed [CW-1:0] tangent_z;
    logic                 degenerate_uv;
    logic                 saturated;
    logic                 last_of_run;
  } tangent_t;

  typedef struct packed {
    logic signed [CW-1:0] quotient;
    logic                 clip;
  } div_result_t;

endpackage
`default_nettype wire

// File: design/triangle_tangent_from_uv.sv
// top level: vertex store, delta setup and sequencer for the per-triangle uv tangent
// Usage:
//   vertex channel (vertex_valid / vertex_ready / vertex) takes one vertex per request:
//   position and texture coordinate in signed Q16.16. Every three vertices form a triangle.
//   The first two vertices of a triangle are only stored.
//   On the third vertex the block forms the deltas, then runs the shared multiplier
//   (eight products, two per pair) and the shared divider (one division per tangent
//   component, cut short when the quotient is out of range); the three divisions run
//   one after another. When the uv determinant is zero, the divisions are skipped
//   and a zero tangent is given.
//   tangent channel (tangent_valid / tangent_ready / tangent) then gives the same
//   tangent three times, last_of_run set on the third; one result per cycle while
//   the receiver takes them. vertex_ready is low from the third vertex until the
//   last result is taken; a stall on the tangent channel simply holds the result.
//   Reset (rst, synchronous) returns to the first vertex of a triangle with no
//   result pending.
`default_nettype none
module triangle_tangent_from_uv
  import ttu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic vertex_valid,
  output logic      vertex_ready,
  input  vertex_t   vertex,
  output logic      tangent_valid,
  input  wire logic tangent_ready,
  output tangent_t  tangent
);

  localparam int OUT_CNT_W = $clog2(TRI_VERTS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MULA = 3'd1;
  localparam logic [2:0] S_MULB = 3'd2;
  localparam logic [2:0] S_SUB  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]           state;
  logic [1:0]           phase;
  logic [1:0]           m;        // 0: determinant, 1..3: tangent component
  logic [OUT_CNT_W-1:0] out_cnt;

  logic signed [CW-1:0]      p0 [3];
  logic signed [CW-1:0]      p1 [3];
  logic signed [CW-1:0]      t0_u, t0_v, t1_u, t1_v;
  logic signed [DELTA_W-1:0] dp1 [3];
  logic signed [DELTA_W-1:0] dp2 [3];
  logic signed [DELTA_W-1:0] du1, dv1, du2, dv2;
  logic signed [PROD_W-1:0]  acc;
  logic signed [WIDE_W-1:0]  d_reg;
  logic signed [CW-1:0]      res [3];
  logic                      degen;
  logic                      clip;

  logic signed [CW-1:0]      vin_p [3];
  logic signed [DELTA_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_q;
  logic signed [WIDE_W-1:0]  diff;
  logic [1:0]                comp;
  logic                      vertex_acc;
  logic                      tangent_acc;
  logic                      div_start;
  logic                      div_done;
  div_result_t               div_res;

  assign vin_p[0] = vertex.pos_x;
  assign vin_p[1] = vertex.pos_y;
  assign vin_p[2] = vertex.pos_z;

  assign vertex_ready  = (state == S_IDLE);
  assign tangent_valid = (state == S_OUT);
  assign vertex_acc    = vertex_valid && vertex_ready;
  assign tangent_acc   = tangent_valid && tangent_ready;

  assign comp      = (m == 2'd0) ? 2'd0 : m - 2'd1;
  assign diff      = WIDE_W'(acc) - WIDE_W'(mul_q);
  assign div_start = (state == S_SUB) && (m != 2'd0);

  // pair m=0 gives du1*dv2 - dv1*du2, pair m gives dp1*dv2 - dp2*dv1
  always_comb begin
    if (state == S_MULB) begin
      mul_a = (m == 2'd0) ? dv1 : dp2[comp];
      mul_b = (m == 2'd0) ? du2 : dv1;
    end else begin
      mul_a = (m == 2'd0) ? du1 : dp1[comp];
      mul_b = dv2;
    end
  end

  ttu_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_q)
  );

  ttu_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (diff),
    .den    (d_reg),
    .done   (div_done),
    .result (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      phase   <= 2'd0;
      m       <= 2'd0;
      out_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (vertex_acc) begin
            unique case (phase)
              2'd1:    phase <= 2'd2;
              2'd2: begin
                phase <= 2'd0;
                m     <= 2'd0;
                state <= S_MULA;
              end
              default: phase <= 2'd1;
            endcase
          end
        end
        S_MULA: state <= S_MULB;
        S_MULB: state <= S_SUB;
        S_SUB: begin
          if (m == 2'd0) begin
            if (diff == '0) begin
              out_cnt <= '0;
              state   <= S_OUT;
            end else begin
              m     <= 2'd1;
              state <= S_MULA;
            end
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (m == 2'd3) begin
              out_cnt <= '0;
              state   <= S_OUT;
            end else begin
              m     <= m + 2'd1;
              state <= S_MULA;
            end
          end
        end
        S_OUT: begin
          if (tangent_acc) begin
            if (out_cnt == OUT_CNT_W'(TRI_VERTS - 1)) begin
              state <= S_IDLE;
            end else begin
              out_cnt <= out_cnt + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && vertex_acc) begin
      unique case (phase)
        2'd1: begin
          for (int j = 0; j < 3; j++) p1[j] <= vin_p[j];
          t1_u <= vertex.tex_u;
          t1_v <= vertex.tex_v;
        end
        2'd2: begin
          for (int j = 0; j < 3; j++) begin
            dp1[j] <= DELTA_W'(p1[j]) - DELTA_W'(p0[j]);
            dp2[j] <= DELTA_W'(vin_p[j]) - DELTA_W'(p0[j]);
          end
          du1 <= DELTA_W'(t1_u) - DELTA_W'(t0_u);
          dv1 <= DELTA_W'(t1_v) - DELTA_W'(t0_v);
          du2 <= DELTA_W'(vertex.tex_u) - DELTA_W'(t0_u);
          dv2 <= DELTA_W'(vertex.tex_v) - DELTA_W'(t0_v);
        end
        default: begin
          for (int j = 0; j < 3; j++) p0[j] <= vin_p[j];
          t0_u <= vertex.tex_u;
          t0_v <= vertex.tex_v;
        end
      endcase
    end
    if (state == S_MULB) acc <= mul_q;
    if (state == S_SUB && m == 2'd0) begin
      d_reg <= diff;
      clip  <= 1'b0;
      degen <= (diff == '0);
      if (diff == '0) begin
        for (int j = 0; j < 3; j++) res[j] <= '0;
      end
    end
    if (state == S_DIV && div_done) begin
      res[comp] <= div_res.quotient;
      clip      <= clip | div_res.clip;
    end
  end

  always_comb begin
    tangent.tangent_x     = res[0];
    tangent.tangent_y     = res[1];
    tangent.tangent_z     = res[2];
    tangent.degenerate_uv = degen;
    tangent.saturated     = clip;
    tangent.last_of_run   = (out_cnt == OUT_CNT_W'(TRI_VERTS - 1));
  end

  // no new request while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(vertex_ready && tangent_valid))
    else $error("vertex_ready while tangent results pending");

  a_busy_after_third: assert property (@(posedge clk) disable iff (rst)
    (vertex_acc && phase == 2'd2) |=> !vertex_ready)
    else $error("ready right after third vertex");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (tangent_acc && tangent.last_of_run) |=> (vertex_ready && !tangent_valid))
    else $error("block not idle after last result");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (tangent_valid && tangent.degenerate_uv) |->
      (tangent.tangent_x == '0 && tangent.tangent_y == '0 &&
       tangent.tangent_z == '0 && !tangent.saturated))
    else $error("degenerate result not zero");

endmodule
`default_nettype wire

// File: design/ttu_mul.sv
// shared signed delta multiplier with registered product
`default_nettype none
module ttu_mul
  import ttu_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic signed [DELTA_W-1:0] a,
  input  wire logic signed [DELTA_W-1:0] b,
  output logic signed [PROD_W-1:0]       prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule
`default_nettype wire

// File: design/ttu_div.sv
// iterative restoring divider for (num << FB) / den with saturation to CW bits
`default_nettype none
module ttu_div
  import ttu_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic signed [WIDE_W-1:0] num,
  input  wire logic signed [WIDE_W-1:0] den,
  output logic                          done,
  output div_result_t                   result
);

  localparam int REM_W = WIDE_W + 1;
  localparam int NSH_W = WIDE_W + FB;
  localparam int CNT_W = $clog2(CW);

  localparam logic [1:0] D_IDLE  = 2'd0;
  localparam logic [1:0] D_CHECK = 2'd1;
  localparam logic [1:0] D_RUN   = 2'd2;
  localparam logic [1:0] D_FIN   = 2'd3;

  logic [1:0]       state;
  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] dmag;
  logic [CW-1:0]    low;
  logic [CW-1:0]    q;
  logic             neg;
  logic             ovf;

  logic [WIDE_W-1:0] num_mag;
  logic [WIDE_W-1:0] den_mag;
  logic [NSH_W-1:0]  nshift;
  logic [REM_W-1:0]  rem2;
  logic              pos_clip;
  logic              neg_clip;

  assign num_mag = num[WIDE_W-1] ? WIDE_W'(-num) : WIDE_W'(num);
  assign den_mag = den[WIDE_W-1] ? WIDE_W'(-den) : WIDE_W'(den);
  assign nshift  = {num_mag, {FB{1'b0}}};
  assign rem2    = {rem[REM_W-2:0], low[CW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        D_IDLE: begin
          if (start) state <= D_CHECK;
        end
        D_CHECK: begin
          cnt   <= '0;
          state <= (rem >= dmag) ? D_FIN : D_RUN;
        end
        D_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(CW - 1)) state <= D_FIN;
        end
        D_FIN: state <= D_IDLE;
        default: state <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      D_IDLE: begin
        if (start) begin
          // quotient reaches 2^CW exactly when the top part already covers the divisor
          rem  <= REM_W'(nshift[NSH_W-1:CW]);
          low  <= nshift[CW-1:0];
          dmag <= REM_W'(den_mag);
          neg  <= num[WIDE_W-1] ^ den[WIDE_W-1];
          q    <= '0;
          ovf  <= 1'b0;
        end
      end
      D_CHECK: begin
        ovf <= (rem >= dmag);
      end
      D_RUN: begin
        low <= {low[CW-2:0], 1'b0};
        if (rem2 >= dmag) begin
          rem <= rem2 - dmag;
          q   <= {q[CW-2:0], 1'b1};
        end else begin
          rem <= rem2;
          q   <= {q[CW-2:0], 1'b0};
        end
      end
      D_FIN: begin
      end
      default: begin
      end
    endcase
  end

  assign pos_clip = ovf | q[CW-1];
  assign neg_clip = ovf | (q[CW-1] & (|q[CW-2:0]));

  always_comb begin
    done = (state == D_FIN);
    if (neg) begin
      result.clip     = neg_clip;
      result.quotient = neg_clip ? {1'b1, {(CW-1){1'b0}}} : CW'(-q);
    end else begin
      result.clip     = pos_clip;
      result.quotient = pos_clip ? {1'b0, {(CW-1){1'b1}}} : q;
    end
  end

endmodule
`default_nettype wire
